>>> rtl/fqdk_pkg.sv
// Package for the FIFO queue with drop by key: sizes, codes, entry types,
// id normalization and circular pointer arithmetic. No dependencies.
package fqdk_pkg;

  localparam int DEPTH       = 16;
  localparam int ID_CHARS    = 6;
  localparam int HANDLE_BITS = 16;

  localparam int IN_ID_W = 48;            // width of the id field on the port
  localparam int ID_W    = ID_CHARS * 8;  // stored id width
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int NAME_W  = 16;            // head_name field on the port
  localparam int COUNT_W = 5;             // entry_count field on the port

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_DROP  = 2'd2,
    REQ_FLUSH = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_RDHEAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [HANDLE_BITS-1:0] name;
  } entry_t;

  typedef struct packed {
    logic   we;
    ptr_t   waddr;
    entry_t wdata;
    ptr_t   raddr;
  } mem_req_t;

  // Id ends at its first zero byte (scanning from the top); later bytes cleared.
  function automatic logic [ID_W-1:0] norm_id(input logic [IN_ID_W-1:0] v);
    logic [ID_W-1:0] r;
    logic            stop;
    logic [7:0]      b;
    r    = '0;
    stop = 1'b0;
    for (int k = ID_CHARS - 1; k >= 0; k--) begin
      b = v[k*8 +: 8];
      if (b == 8'd0) stop = 1'b1;
      if (!stop) r[k*8 +: 8] = b;
    end
    return r;
  endfunction

  // (a + b) mod DEPTH for a, b below DEPTH.
  function automatic ptr_t wrap_add(input ptr_t a, input ptr_t b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W + 1)'(DEPTH)) s = s - (PTR_W + 1)'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

endpackage

>>> rtl/fifo_queue_with_drop_by_key.sv
// Top level of the FIFO queue with drop by key: request sequencer, counters
// and result register. Depends on fqdk_pkg and fqdk_store.
//
// Usage:
//   Requests come in on the in_ stream, one item each: enqueue, dequeue,
//   drop by id, or flush. Each gives exactly one result item on the out_
//   stream: success, head valid, head name handle, entry count.
//   The queue is a circular buffer in a RAM with one registered read port;
//   one shared id comparator and a small sequencer do a drop. A drop walks
//   the entries from the head (read, then compare), then closes the
//   gap by moving each younger entry one slot forward (read, write).
//   A drop that hits the head just advances the head pointer.
//   in_tready is high only while the sequencer is idle: one request at a
//   time; a new request is taken only after the last result is registered.
//   Reset empties the queue at once (count and head pointer cleared); RAM
//   contents are not cleared. A stalled receiver holds the result in the
//   output register; the next request is still taken and processed, and its
//   result waits until the register frees up.
module fifo_queue_with_drop_by_key (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [47:0] id_chars, [48] id_too_long, [64:49] name_handle, [71:65] zero
  input  logic [71:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] success, [1] head_valid, [17:2] head_name, [22:18] entry_count,
  // [23] zero
  output logic [23:0] out_tdata
);

  fqdk_pkg::state_t state_r, state_nxt;
  fqdk_pkg::ptr_t   hd_r, hd_nxt;
  fqdk_pkg::cnt_t   cnt_r, cnt_nxt;
  fqdk_pkg::cnt_t   idx_r, idx_nxt;   // search / move position, from the head
  logic             ok_r, ok_nxt;

  // latched request
  fqdk_pkg::req_t                   req_r, req_nxt;
  logic [fqdk_pkg::ID_W-1:0]        id_r, id_nxt;
  logic                             tl_r, tl_nxt;
  logic [fqdk_pkg::HANDLE_BITS-1:0] hdl_r, hdl_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  fqdk_pkg::mem_req_t mreq;
  fqdk_pkg::entry_t   rdata;
  fqdk_pkg::cnt_t     idx_inc;
  logic               id_hit;
  logic               head_v;
  logic [fqdk_pkg::NAME_W-1:0] head_nm;

  fqdk_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign idx_inc   = idx_r + fqdk_pkg::cnt_t'(1);
  assign id_hit    = (rdata.id == id_r);   // the shared comparator
  assign in_tready = (state_r == fqdk_pkg::S_IDLE);
  assign head_v    = (cnt_r != '0);
  assign head_nm   = head_v ? fqdk_pkg::NAME_W'(rdata.name) : '0;

  always_comb begin
    state_nxt     = state_r;
    hd_nxt        = hd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    ok_nxt        = ok_r;
    req_nxt       = req_r;
    id_nxt        = id_r;
    tl_nxt        = tl_r;
    hdl_nxt       = hdl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mreq.we       = 1'b0;
    mreq.waddr    = fqdk_pkg::wrap_add(hd_r, idx_r[fqdk_pkg::PTR_W-1:0]);
    mreq.wdata    = rdata;
    mreq.raddr    = hd_r;

    unique case (state_r)
      fqdk_pkg::S_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = fqdk_pkg::req_t'(in_tuser);
          id_nxt    = fqdk_pkg::norm_id(in_tdata[47:0]);
          tl_nxt    = in_tdata[48];
          hdl_nxt   = in_tdata[64:49];
          state_nxt = fqdk_pkg::S_EXEC;
        end
      end
      fqdk_pkg::S_EXEC: begin
        ok_nxt    = 1'b0;
        idx_nxt   = '0;
        state_nxt = fqdk_pkg::S_RDHEAD;
        case (req_r)
          fqdk_pkg::REQ_ENQ: begin
            if (!tl_r && cnt_r < fqdk_pkg::cnt_t'(fqdk_pkg::DEPTH)) begin
              mreq.we    = 1'b1;
              mreq.waddr = fqdk_pkg::wrap_add(hd_r, cnt_r[fqdk_pkg::PTR_W-1:0]);
              mreq.wdata = '{id: id_r, name: hdl_r};
              cnt_nxt    = cnt_r + fqdk_pkg::cnt_t'(1);
              ok_nxt     = 1'b1;
            end
          end
          fqdk_pkg::REQ_DEQ: begin
            if (cnt_r != '0) begin
              hd_nxt  = fqdk_pkg::wrap_add(hd_r, fqdk_pkg::ptr_t'(1));
              cnt_nxt = cnt_r - fqdk_pkg::cnt_t'(1);
              ok_nxt  = 1'b1;
            end
          end
          fqdk_pkg::REQ_DROP: begin
            if (!tl_r && cnt_r != '0) state_nxt = fqdk_pkg::S_SRCH;
          end
          default: begin  // flush
            hd_nxt  = '0;
            cnt_nxt = '0;
            ok_nxt  = 1'b1;
          end
        endcase
      end
      fqdk_pkg::S_SRCH: begin
        mreq.raddr = fqdk_pkg::wrap_add(hd_r, idx_r[fqdk_pkg::PTR_W-1:0]);
        state_nxt  = fqdk_pkg::S_CMP;
      end
      fqdk_pkg::S_CMP: begin
        if (id_hit) begin
          ok_nxt = 1'b1;
          if (idx_r == '0) begin
            // head hit: advance the head, nothing to move
            hd_nxt    = fqdk_pkg::wrap_add(hd_r, fqdk_pkg::ptr_t'(1));
            cnt_nxt   = cnt_r - fqdk_pkg::cnt_t'(1);
            state_nxt = fqdk_pkg::S_RDHEAD;
          end else begin
            state_nxt = fqdk_pkg::S_SHRD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == cnt_r) ? fqdk_pkg::S_RDHEAD : fqdk_pkg::S_SRCH;
        end
      end
      fqdk_pkg::S_SHRD: begin
        if (idx_inc >= cnt_r) begin
          cnt_nxt   = cnt_r - fqdk_pkg::cnt_t'(1);
          state_nxt = fqdk_pkg::S_RDHEAD;
        end else begin
          mreq.raddr = fqdk_pkg::wrap_add(hd_r, idx_inc[fqdk_pkg::PTR_W-1:0]);
          state_nxt  = fqdk_pkg::S_SHWR;
        end
      end
      fqdk_pkg::S_SHWR: begin
        // younger entry moves one slot toward the head
        mreq.we   = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = fqdk_pkg::S_SHRD;
      end
      fqdk_pkg::S_RDHEAD: begin
        state_nxt = fqdk_pkg::S_DONE;
      end
      fqdk_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, fqdk_pkg::COUNT_W'(cnt_r), head_nm, head_v, ok_r};
          state_nxt     = fqdk_pkg::S_IDLE;
        end
      end
      default: state_nxt = fqdk_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqdk_pkg::S_IDLE;
      hd_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hd_r        <= hd_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    id_r       <= id_nxt;
    tl_r       <= tl_nxt;
    hdl_r      <= hdl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // fill level never passes the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fqdk_pkg::cnt_t'(fqdk_pkg::DEPTH))
    else $error("entry count above depth");

  // one request at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");

  // head_valid agrees with the reported count, and an empty queue reports name 0
  a_head_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1] == (out_tdata[22:18] != 5'd0)) &&
                   (out_tdata[1] || out_tdata[17:2] == 16'd0))
    else $error("head fields disagree with count");

endmodule

>>> rtl/fqdk_store.sv
// Entry store of the queue: one write port, one registered read port.
// Depends on fqdk_pkg for the entry and request types.
module fqdk_store (
  input  logic               clk,
  input  fqdk_pkg::mem_req_t req,
  output fqdk_pkg::entry_t   rdata
);

  fqdk_pkg::entry_t mem [fqdk_pkg::DEPTH];
  fqdk_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> verif/fifo_queue_with_drop_by_key_tb.sv
// Self-checking testbench for fifo_queue_with_drop_by_key: a directed table,
// then random request sequences, checked against a queue-based predictor.
// Depends on fqdk_pkg and the block's RTL.
`timescale 1ns / 100ps

module fifo_queue_with_drop_by_key_tb;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          RANDOM_ITEMS = 1300;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          HOLD_CYCLES  = 400;

  // Result fields, declared top down so the struct lines up with out_tdata.
  typedef struct packed {
    logic [4:0]  entry_count;
    logic [15:0] head_name;
    logic        head_valid;
    logic        success;
  } status_t;

  typedef struct {
    fqdk_pkg::req_t kind;
    logic [47:0]    id;
    logic           too_long;
    logic [15:0]    handle;
  } request_t;

  typedef struct {
    request_t rq;
    bit       typed;   // expected status typed into the table
    status_t  want;
  } table_row_t;

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_HALF, RDY_SPARSE} ready_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  fifo_queue_with_drop_by_key dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Predicted queue contents, slot 0 is the head.
  logic [47:0] held_ids[$];
  logic [15:0] held_names[$];
  status_t     status_due[$];
  table_row_t  script[$];
  logic [47:0] id_pool[8];

  int          errors     = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  // An id ends at its first zero byte; everything below it is cleared.
  function automatic logic [47:0] trim_id(input logic [47:0] raw);
    logic [48:0] low_mask;
    for (int b = 5; b >= 0; b--)
      if (raw[b*8 +: 8] == 8'h00) begin
        low_mask = (49'd1 << (b * 8 + 8)) - 49'd1;
        return raw & ~low_mask[47:0];
      end
    return raw;
  endfunction

  // Apply one request to the predicted queue, return the status it reports.
  function automatic status_t apply_request(input request_t rq);
    status_t     s;
    logic [47:0] key;
    int          hit;
    s   = '0;
    key = trim_id(rq.id);
    hit = -1;
    case (rq.kind)
      fqdk_pkg::REQ_ENQ: begin
        if (!rq.too_long && held_ids.size() < fqdk_pkg::DEPTH) begin
          held_ids.push_back(key);
          held_names.push_back(rq.handle);
          s.success = 1'b1;
        end
      end
      fqdk_pkg::REQ_DEQ: begin
        if (held_ids.size() > 0) begin
          void'(held_ids.pop_front());
          void'(held_names.pop_front());
          s.success = 1'b1;
        end
      end
      fqdk_pkg::REQ_DROP: begin
        // too-long ids never match; oldest match wins
        if (!rq.too_long)
          foreach (held_ids[i])
            if (hit < 0 && held_ids[i] == key) hit = i;
        if (hit >= 0) begin
          held_ids.delete(hit);
          held_names.delete(hit);
          s.success = 1'b1;
        end
      end
      fqdk_pkg::REQ_FLUSH: begin
        held_ids.delete();
        held_names.delete();
        s.success = 1'b1;
      end
    endcase
    s.head_valid  = (held_ids.size() > 0);
    s.head_name   = (held_ids.size() > 0) ? held_names[0] : 16'h0000;
    s.entry_count = 5'(held_ids.size());
    return s;
  endfunction

  function automatic status_t mk_status(input logic ok, input logic hv,
                                        input logic [15:0] hn, input int cnt);
    status_t s;
    s.success     = ok;
    s.head_valid  = hv;
    s.head_name   = hn;
    s.entry_count = 5'(cnt);
    return s;
  endfunction

  function automatic request_t mk_req(input fqdk_pkg::req_t kind, input logic [47:0] id,
                                      input logic tl, input logic [15:0] h);
    request_t rq;
    rq.kind     = kind;
    rq.id       = id;
    rq.too_long = tl;
    rq.handle   = h;
    return rq;
  endfunction

  task automatic add_row(input fqdk_pkg::req_t kind, input logic [47:0] id,
                         input logic tl, input logic [15:0] h, input bit typed,
                         input status_t want);
    table_row_t row;
    row.rq    = mk_req(kind, id, tl, h);
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endtask

  // Random id of len chars, zero padded below.
  function automatic logic [47:0] make_id(input int len);
    logic [47:0] v;
    v = '0;
    for (int b = 5; b > 5 - len; b--) v[b*8 +: 8] = 8'($urandom_range(1, 255));
    return v;
  endfunction

  // Fill the bytes below the terminating zero with garbage.
  function automatic logic [47:0] add_junk(input logic [47:0] id);
    logic [47:0] v;
    int          n;
    v = id;
    n = 0;
    while (n < 6 && id[(5 - n)*8 +: 8] != 8'h00) n++;
    for (int b = 0; b < 5 - n; b++) v[b*8 +: 8] = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic logic [47:0] pool_id();
    logic [47:0] v;
    v = id_pool[$urandom_range(0, 7)];
    return $urandom_range(0, 1) ? add_junk(v) : v;
  endfunction

  // Offer one item in sender bursts; on acceptance record what it should report.
  // Entered and left at a rising edge.
  task automatic send(input request_t rq, input bit typed, input status_t want);
    int      gap;
    status_t got;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, rq.handle, rq.too_long, rq.id};
    in_tuser  <= rq.kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = apply_request(rq);
    status_due.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic send_random(input fqdk_pkg::req_t kind, input logic [47:0] id,
                             input logic tl);
    send(mk_req(kind, id, tl, 16'($urandom_range(0, 65535))), 1'b0, '0);
  endtask

  initial begin
    int roll;
    int n;

    // Directed table: empty-queue corners, extremes, normalization,
    // drop of tail / head / no match, flush.
    add_row(fqdk_pkg::REQ_DEQ,   48'h0,              1'b0, 16'h0000,
            1, mk_status(0, 0, 16'h0000, 0));
    add_row(fqdk_pkg::REQ_DROP,  48'h0,              1'b0, 16'h0000,
            1, mk_status(0, 0, 16'h0000, 0));
    add_row(fqdk_pkg::REQ_FLUSH, 48'h0,              1'b0, 16'h0000,
            1, mk_status(1, 0, 16'h0000, 0));
    add_row(fqdk_pkg::REQ_ENQ,   48'hFFFF_FFFF_FFFF, 1'b1, 16'hFFFF,
            1, mk_status(0, 0, 16'h0000, 0));
    add_row(fqdk_pkg::REQ_ENQ,   48'hFFFF_FFFF_FFFF, 1'b0, 16'hFFFF,
            1, mk_status(1, 1, 16'hFFFF, 1));
    add_row(fqdk_pkg::REQ_ENQ,   48'h0,              1'b0, 16'h0000,
            1, mk_status(1, 1, 16'hFFFF, 2));
    add_row(fqdk_pkg::REQ_ENQ,   48'h6162_0063_6400, 1'b0, 16'h1234,
            1, mk_status(1, 1, 16'hFFFF, 3));
    // too-long drop misses even though the id matches the head
    add_row(fqdk_pkg::REQ_DROP,  48'hFFFF_FFFF_FFFF, 1'b1, 16'h0000,
            1, mk_status(0, 1, 16'hFFFF, 3));
    add_row(fqdk_pkg::REQ_DROP,  48'h6162_00FF_FFFF, 1'b0, 16'h0000, 0, '0);
    add_row(fqdk_pkg::REQ_DROP,  48'h00FF_FFFF_FFFF, 1'b0, 16'h0000, 0, '0);
    add_row(fqdk_pkg::REQ_DROP,  48'hFFFF_FFFF_FFFF, 1'b0, 16'h0000,
            1, mk_status(1, 0, 16'h0000, 0));
    add_row(fqdk_pkg::REQ_ENQ,   48'h4100_FFFF_FFFF, 1'b0, 16'h0001, 0, '0);
    add_row(fqdk_pkg::REQ_ENQ,   48'h4100_0000_0000, 1'b0, 16'h0002, 0, '0);
    add_row(fqdk_pkg::REQ_ENQ,   48'h4200_0000_0000, 1'b0, 16'h0003, 0, '0);
    add_row(fqdk_pkg::REQ_DROP,  48'h4300_0000_0000, 1'b0, 16'h0000,
            1, mk_status(0, 1, 16'h0001, 3));
    add_row(fqdk_pkg::REQ_DROP,  48'h4100_1234_5678, 1'b0, 16'h0000,
            1, mk_status(1, 1, 16'h0002, 2));
    add_row(fqdk_pkg::REQ_DEQ,   48'h0,              1'b0, 16'h0000,
            1, mk_status(1, 1, 16'h0003, 1));
    add_row(fqdk_pkg::REQ_FLUSH, 48'h0,              1'b0, 16'h0000,
            1, mk_status(1, 0, 16'h0000, 0));
    add_row(fqdk_pkg::REQ_DEQ,   48'h0,              1'b0, 16'h0000,
            1, mk_status(0, 0, 16'h0000, 0));

    // Small id pool so drops hit often and duplicates show up.
    foreach (id_pool[i]) id_pool[i] = make_id($urandom_range(0, 6));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    foreach (script[i]) send(script[i].rq, script[i].typed, script[i].want);

    while (items_sent < script.size() + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        // enqueue run, long enough at times to hit the full queue
        n = $urandom_range(1, fqdk_pkg::DEPTH + 3);
        repeat (n) send_random(fqdk_pkg::REQ_ENQ, pool_id(), $urandom_range(0, 15) == 0);
      end else if (roll < 45) begin
        // drop an id that is held, anywhere in the queue; a pool id if it is empty
        if (held_ids.size() > 0)
          send_random(fqdk_pkg::REQ_DROP,
                      add_junk(held_ids[$urandom_range(0, held_ids.size() - 1)]),
                      $urandom_range(0, 15) == 0);
        else
          send_random(fqdk_pkg::REQ_DROP, pool_id(), 1'b0);
      end else if (roll < 60) begin
        n = $urandom_range(1, 6);
        repeat (n) send_random(fqdk_pkg::REQ_DEQ, pool_id(), 1'b0);
      end else if (roll < 70) begin
        send_random(fqdk_pkg::REQ_DROP, pool_id(), $urandom_range(0, 7) == 0);
      end else if (roll < 75) begin
        send_random(fqdk_pkg::REQ_FLUSH, pool_id(), 1'($urandom_range(0, 1)));
      end else begin
        // noise: every field fully random
        send_random(fqdk_pkg::req_t'($urandom_range(0, 3)),
                    {16'($urandom_range(0, 65535)), 32'($urandom())},
                    1'($urandom_range(0, 1)));
      end
    end

    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && status_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  function automatic void report_diff(input string what, input status_t want,
                                      input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h (status %h)",
               $time, what, exp_v, act_v, want);
      errors++;
    end
  endfunction

  // Receiver: checks results and stalls on its own pattern, with long holds
  // so the block fills up and pushes back on the sender.
  ready_mode_t ready_mode   = RDY_ALWAYS;
  int          mode_left    = 0;
  int          hold_left    = 0;
  int          holds_done   = 0;
  int          results_seen = 0;

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = status_t'(out_tdata[22:0]);
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = status_due.pop_front();
        report_diff("success",     want, want.success,     got.success);
        report_diff("head_valid",  want, want.head_valid,  got.head_valid);
        report_diff("head_name",   want, want.head_name,   got.head_name);
        report_diff("entry_count", want, want.entry_count, got.entry_count);
      end
      results_seen++;
    end

    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 150 : 700)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      case (ready_mode)
        RDY_ALWAYS: out_tready <= 1'b1;
        RDY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        RDY_HALF:   out_tready <= 1'($urandom_range(0, 1));
        default:    out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog.
  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/fqdk_pkg.sv
rtl/fqdk_store.sv
rtl/fifo_queue_with_drop_by_key.sv
verif/fifo_queue_with_drop_by_key_tb.sv
